// ----- hw/rtl/als_lux_from_channel_ratio_top_assert.svh -----
// Assertion macros shared by the ambient light lux converter RTL.
`ifndef ALS_LUX_FROM_CHANNEL_RATIO_TOP_ASSERT_SVH
`define ALS_LUX_FROM_CHANNEL_RATIO_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALSLUX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALSLUX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/alslux_pkg.sv -----
// Package with types, constants and the power table of the lux converter.
`default_nettype none

package alslux_pkg;

    localparam int RATIO_FRAC_BITS   = 16;
    localparam int POW_TABLE_ENTRIES = 256;

    localparam int CH_W      = 16;
    localparam int SCALE_W   = 11;
    localparam int LUX_W     = 22;
    localparam int BAND_W    = 3;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 20;
    localparam int D_W       = CH_W + SCALE_W;
    localparam int PROD_W    = D_W + COEF_W;
    localparam int CMP_W     = CH_W + 8;
    localparam int POW_W     = 16;
    localparam int POW_FRAC  = 16;
    localparam int IDX_W     = $clog2(POW_TABLE_ENTRIES);
    localparam int IDXF_W    = RATIO_FRAC_BITS + IDX_W + 1;

    localparam logic [CH_W-1:0]    FULL_SCALE  = CH_W'(65535);
    localparam logic [LUX_W-1:0]   LUX_MAX     = LUX_W'(4194303);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(515);

    localparam logic [CMP_W-1:0] PCT_SCALE = CMP_W'(100);
    localparam logic [CMP_W-1:0] LIM_050   = CMP_W'(50);
    localparam logic [CMP_W-1:0] LIM_061   = CMP_W'(61);
    localparam logic [CMP_W-1:0] LIM_080   = CMP_W'(80);
    localparam logic [CMP_W-1:0] LIM_130   = CMP_W'(130);

    localparam logic [COEF_W-1:0] K_0304  = COEF_W'(31877);
    localparam logic [COEF_W-1:0] K_062   = COEF_W'(65012);
    localparam logic [COEF_W-1:0] K_0224  = COEF_W'(23488);
    localparam logic [COEF_W-1:0] K_031   = COEF_W'(32506);
    localparam logic [COEF_W-1:0] K_0128  = COEF_W'(13422);
    localparam logic [COEF_W-1:0] K_0153  = COEF_W'(16043);
    localparam logic [COEF_W-1:0] K_00146 = COEF_W'(1531);
    localparam logic [COEF_W-1:0] K_00112 = COEF_W'(1174);

    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = (RATIO_FRAC_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam int S_IN          = 0;
    localparam int S_BAND        = 1;
    localparam int S_DIV0        = 2;
    localparam int S_ROM         = S_DIV0 + DIV_STAGES;
    localparam int S_NEG         = S_ROM + 1;
    localparam int S_OUT         = S_NEG + 1;
    localparam int NUM_STAGES    = S_OUT + 1;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] POW_X_DIV = 64'(2 * POW_TABLE_ENTRIES);

    typedef enum logic [BAND_W-1:0] {
        BAND_LT_050       = 3'd0,
        BAND_LT_061       = 3'd1,
        BAND_LT_080       = 3'd2,
        BAND_LT_130       = 3'd3,
        BAND_ZERO_OR_HIGH = 3'd4,
        BAND_SATURATED    = 3'd5
    } t_band;

    typedef struct packed {
        logic [CH_W-1:0]            ch0;
        logic [CH_W-1:0]            ch1;
        logic [SCALE_W-1:0]         scale;
        logic [D_W-1:0]             d0;
        logic [D_W-1:0]             d1;
        t_band                      band;
        logic [CH_W-1:0]            rem;
        logic [RATIO_FRAC_BITS-1:0] quo;
        logic [PROD_W-1:0]          pos;
        logic [PROD_W-1:0]          neg;
        logic [POW_W-1:0]           tval;
        logic [LUX_W-1:0]           lux;
    } t_stage;

    typedef logic [POW_W-1:0] t_pow_rom [POW_TABLE_ENTRIES];

    function automatic logic [COEF_W-1:0] f_coef_pos(t_band band);
        case (band)
            BAND_LT_050: return K_0304;
            BAND_LT_061: return K_0224;
            BAND_LT_080: return K_0128;
            BAND_LT_130: return K_00146;
            default:     return '0;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] f_coef_neg(t_band band);
        case (band)
            BAND_LT_050: return K_062;
            BAND_LT_061: return K_031;
            BAND_LT_080: return K_0153;
            BAND_LT_130: return K_00112;
            default:     return '0;
        endcase
    endfunction

    function automatic logic [63:0] f_q30_mul(logic [63:0] a, logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    function automatic logic [63:0] f_q30_pow5(logic [63:0] y);
        logic [63:0] p;
        p = y;
        for (int k = 0; k < 4; k++) begin
            p = f_q30_mul(p, y);
        end
        return p;
    endfunction

    // Entry i holds x^1.4 in Q16 for x = i / (2 * entries), found as the
    // largest Q30 value whose fifth power stays at or below x^7.
    function automatic logic [POW_W-1:0] f_pow_entry(int idx);
        logic [63:0] x;
        logic [63:0] x7;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        x  = (64'(idx) << 30) / POW_X_DIV;
        x7 = x;
        lo = '0;
        hi = Q30_ONE - 64'd1;
        for (int k = 0; k < 6; k++) begin
            x7 = f_q30_mul(x7, x);
        end
        for (int k = 0; k < 32; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (f_q30_pow5(mid) <= x7) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return POW_W'(lo >> 14);
    endfunction

    function automatic t_pow_rom f_build_pow_rom();
        t_pow_rom rom;
        for (int i = 0; i < POW_TABLE_ENTRIES; i++) begin
            rom[i] = f_pow_entry(i);
        end
        return rom;
    endfunction

    localparam t_pow_rom POW_ROM = f_build_pow_rom();

endpackage

`default_nettype wire

// ----- hw/rtl/alslux_in_if.sv -----
// Interface for the channel count input stream.
`default_nettype none

interface alslux_in_if;
    import alslux_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch0_count;
    logic [CH_W-1:0] ch1_count;

    modport source (output valid, output ch0_count, output ch1_count, input ready);
    modport sink (input valid, input ch0_count, input ch1_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/alslux_out_if.sv -----
// Interface for the lux result stream.
`default_nettype none

interface alslux_out_if;
    import alslux_pkg::*;

    logic              valid;
    logic              ready;
    logic [LUX_W-1:0]  lux_q8;
    logic [BAND_W-1:0] ratio_band;

    modport source (output valid, output lux_q8, output ratio_band, input ready);
    modport sink (input valid, input lux_q8, input ratio_band, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/als_lux_from_channel_ratio_top.sv -----
// Throughput: one transaction per cycle unless the output stalls;
// the ratio divider retires two quotient bits per stage.
// Each stage moves on when it is empty or its successor moves, so bubbles are squeezed out.
// Reset is synchronous and active low: it clears all stage valid bits and loads the
// integration scale register with 515.
`default_nettype none

`include "als_lux_from_channel_ratio_top_assert.svh"

module als_lux_from_channel_ratio_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [alslux_pkg::SCALE_W-1:0] i_cfg_wdata,
    alslux_in_if.sink                     i_samp,
    alslux_out_if.source                  o_lux
);
    import alslux_pkg::*;

    logic [SCALE_W-1:0]    r_scale;
    logic [NUM_STAGES-1:0] r_v;
    t_stage                r_st [NUM_STAGES];
    t_stage                n_st [NUM_STAGES];
    logic [NUM_STAGES-1:0] stage_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    always_comb begin
        stage_adv[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || o_lux.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_adv[k] = !r_v[k] || stage_adv[k+1];
        end
    end

    assign i_samp.ready = stage_adv[S_IN];

    always_comb begin
        t_stage                cur;
        logic [CMP_W-1:0]      h1;
        logic [CMP_W-1:0]      c0;
        logic [CH_W:0]         rem2;
        logic [D_W-1:0]        neg_src;
        logic [IDXF_W-1:0]     idx_full;
        logic [IDX_W-1:0]      idx;
        logic [PROD_W+POW_W-1:0] prod_t;
        logic [PROD_W-1:0]     diff;
        logic [PROD_W-COEF_FRAC-1:0] lux_full;

        cur      = '0;
        h1       = '0;
        c0       = '0;
        rem2     = '0;
        neg_src  = '0;
        idx_full = '0;
        idx      = '0;
        prod_t   = '0;
        diff     = '0;
        lux_full = '0;

        n_st[S_IN]       = '0;
        n_st[S_IN].ch0   = i_samp.ch0_count;
        n_st[S_IN].ch1   = i_samp.ch1_count;
        n_st[S_IN].scale = r_scale;
        n_st[S_IN].band  = BAND_ZERO_OR_HIGH;

        for (int k = 1; k < NUM_STAGES; k++) begin
            cur = r_st[k-1];

            if (k == S_BAND) begin
                cur.d0  = D_W'(cur.ch0) * D_W'(cur.scale);
                cur.d1  = D_W'(cur.ch1) * D_W'(cur.scale);
                cur.rem = cur.ch1;
                cur.quo = '0;
                h1 = CMP_W'(cur.ch1) * PCT_SCALE;
                c0 = CMP_W'(cur.ch0);
                if (cur.ch0 == FULL_SCALE || cur.ch1 == FULL_SCALE) begin
                    cur.band = BAND_SATURATED;
                end else if (h1 < c0 * LIM_050) begin
                    cur.band = BAND_LT_050;
                end else if (h1 < c0 * LIM_061) begin
                    cur.band = BAND_LT_061;
                end else if (h1 < c0 * LIM_080) begin
                    cur.band = BAND_LT_080;
                end else if (h1 < c0 * LIM_130) begin
                    cur.band = BAND_LT_130;
                end else begin
                    cur.band = BAND_ZERO_OR_HIGH;
                end
            end

            if (k == S_DIV0) begin
                neg_src = (cur.band == BAND_LT_050) ? cur.d0 : cur.d1;
                cur.pos = PROD_W'(cur.d0) * PROD_W'(f_coef_pos(cur.band));
                cur.neg = PROD_W'(neg_src) * PROD_W'(f_coef_neg(cur.band));
            end

            if (k >= S_DIV0 && k < S_ROM) begin
                for (int j = 0; j < DIV_PER_STAGE; j++) begin
                    if ((k - S_DIV0) * DIV_PER_STAGE + j < RATIO_FRAC_BITS) begin
                        rem2 = {cur.rem, 1'b0};
                        if (rem2 >= {1'b0, cur.ch0}) begin
                            cur.rem = CH_W'(rem2 - {1'b0, cur.ch0});
                            cur.quo = {cur.quo[RATIO_FRAC_BITS-2:0], 1'b1};
                        end else begin
                            cur.rem = rem2[CH_W-1:0];
                            cur.quo = {cur.quo[RATIO_FRAC_BITS-2:0], 1'b0};
                        end
                    end
                end
            end

            if (k == S_ROM) begin
                idx_full = (IDXF_W'(cur.quo) << (IDX_W + 1)) >> RATIO_FRAC_BITS;
                if (idx_full >= IDXF_W'(POW_TABLE_ENTRIES)) begin
                    idx = IDX_W'(POW_TABLE_ENTRIES - 1);
                end else begin
                    idx = idx_full[IDX_W-1:0];
                end
                cur.tval = POW_ROM[idx];
            end

            if (k == S_NEG) begin
                if (cur.band == BAND_LT_050) begin
                    prod_t  = (PROD_W + POW_W)'(cur.neg) * (PROD_W + POW_W)'(cur.tval);
                    cur.neg = PROD_W'(prod_t >> POW_FRAC);
                end
            end

            if (k == S_OUT) begin
                if (cur.pos > cur.neg) begin
                    diff     = cur.pos - cur.neg;
                    lux_full = diff[PROD_W-1:COEF_FRAC];
                    if (lux_full > (PROD_W - COEF_FRAC)'(LUX_MAX)) begin
                        cur.lux = LUX_MAX;
                    end else begin
                        cur.lux = lux_full[LUX_W-1:0];
                    end
                end else begin
                    cur.lux = '0;
                end
            end

            n_st[k] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_adv[S_IN]) begin
                r_v[S_IN] <= i_samp.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_adv[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_lux.valid      = r_v[S_OUT];
    assign o_lux.lux_q8     = r_st[S_OUT].lux;
    assign o_lux.ratio_band = BAND_W'(r_st[S_OUT].band);

    `ALSLUX_ASSERT_NEXT(a_accept_fills_entry, i_clk, i_rst_n,
        i_samp.valid && i_samp.ready, r_v[S_IN], "Accepted transaction did not enter the pipeline")

    `ALSLUX_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n,
        !i_samp.ready, &r_v, "Input stalled while a pipeline stage was empty")

    `ALSLUX_ASSERT_SAME(a_low_band_ratio, i_clk, i_rst_n,
        r_v[S_ROM-1] && r_st[S_ROM-1].band == BAND_LT_050,
        !r_st[S_ROM-1].quo[RATIO_FRAC_BITS-1], "Low band ratio reached one half")

    `ALSLUX_ASSERT_SAME(a_dead_band_zero, i_clk, i_rst_n,
        r_v[S_OUT] && (r_st[S_OUT].band == BAND_ZERO_OR_HIGH ||
        r_st[S_OUT].band == BAND_SATURATED), r_st[S_OUT].lux == '0,
        "Nonzero lux in an out-of-range band")

endmodule

`default_nettype wire

// ----- verif/als_lux_from_channel_ratio_top_test.sv -----
// Self-checking testbench of the two-channel ambient light lux converter with its own predictor.
`timescale 1ns / 100ps

module als_lux_from_channel_ratio_top_test;
    import alslux_pkg::CH_W;
    import alslux_pkg::SCALE_W;
    import alslux_pkg::LUX_W;
    import alslux_pkg::t_band;
    import alslux_pkg::BAND_LT_050;
    import alslux_pkg::BAND_LT_061;
    import alslux_pkg::BAND_LT_080;
    import alslux_pkg::BAND_LT_130;
    import alslux_pkg::BAND_ZERO_OR_HIGH;
    import alslux_pkg::BAND_SATURATED;

    localparam int          RATIO_BITS   = 16;
    localparam int          POW_ENTRIES  = 256;
    localparam int          COUNT_FULL   = 65535;
    localparam int          SCALE_AT_RST = 515;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [63:0] LUX_SAT      = 64'd4194303;

    localparam logic [63:0] C_VIS_LOW  = 64'd31877;
    localparam logic [63:0] C_IR_LOW   = 64'd65012;
    localparam logic [63:0] C_VIS_MID1 = 64'd23488;
    localparam logic [63:0] C_IR_MID1  = 64'd32506;
    localparam logic [63:0] C_VIS_MID2 = 64'd13422;
    localparam logic [63:0] C_IR_MID2  = 64'd16043;
    localparam logic [63:0] C_VIS_HIGH = 64'd1531;
    localparam logic [63:0] C_IR_HIGH  = 64'd1174;

    typedef struct {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
    } t_counts;

    typedef struct {
        logic [LUX_W-1:0] lux;
        t_band            band;
    } t_lux_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [SCALE_W-1:0] i_cfg_wdata;

    alslux_in_if  samp_bus ();
    alslux_out_if lux_bus ();

    als_lux_from_channel_ratio_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_samp      (samp_bus),
        .o_lux       (lux_bus)
    );

    logic [15:0]  pow_tab [POW_ENTRIES];
    logic [SCALE_W-1:0] scale_model;
    t_counts      counts_pending_q[$];
    t_lux_result  lux_expected_q[$];
    int           mismatches;
    int           sent_count;
    int           checked_count;
    int           settings_used;
    int           band_hits [6];
    int           burst_left;
    int           gap_left;
    bit           offer_held;
    bit           hold_armed;
    bit           hold_done;
    int           hold_left;
    logic [31:0]  ready_pat;
    int           pat_pos;
    t_lux_result  lux_exp;

    function automatic logic [63:0] q30_mult(logic [63:0] a, logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    function automatic logic [63:0] q30_fifth(logic [63:0] y);
        logic [63:0] p;
        p = y;
        for (int k = 0; k < 4; k++) begin
            p = q30_mult(p, y);
        end
        return p;
    endfunction

    // Each entry is x^1.4 in Q16, found as the largest y with y^5 <= x^7 in Q30.
    task automatic build_pow_table();
        logic [63:0] x;
        logic [63:0] x7;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        for (int i = 0; i < POW_ENTRIES; i++) begin
            x  = (64'(i) << 30) / 64'(2 * POW_ENTRIES);
            x7 = x;
            for (int k = 0; k < 6; k++) begin
                x7 = q30_mult(x7, x);
            end
            lo = '0;
            hi = (64'd1 << 30) - 64'd1;
            while (lo < hi) begin
                mid = lo + (hi - lo + 64'd1) / 64'd2;
                if (q30_fifth(mid) <= x7) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
            pow_tab[i] = 16'(lo >> 14);
        end
    endtask

    function automatic t_lux_result predict_lux(logic [CH_W-1:0] c0, logic [CH_W-1:0] c1,
                                                logic [SCALE_W-1:0] scale);
        t_lux_result r;
        logic [63:0] d0;
        logic [63:0] d1;
        logic [63:0] pct1;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] ratio;
        logic [63:0] idx;
        logic [63:0] diff;
        r.lux = '0;
        r.band = BAND_ZERO_OR_HIGH;
        if (c0 == CH_W'(COUNT_FULL) || c1 == CH_W'(COUNT_FULL)) begin
            r.band = BAND_SATURATED;
            return r;
        end
        if (c0 == '0) begin
            return r;
        end
        d0   = 64'(c0) * 64'(scale);
        d1   = 64'(c1) * 64'(scale);
        pct1 = 64'(c1) * 64'd100;
        pos  = '0;
        neg  = '0;
        if (pct1 < 64'd50 * 64'(c0)) begin
            ratio = (64'(c1) << RATIO_BITS) / 64'(c0);
            if (ratio > (64'd1 << (RATIO_BITS + 2)) - 64'd1) begin
                ratio = (64'd1 << (RATIO_BITS + 2)) - 64'd1;
            end
            idx = (ratio * 64'(2 * POW_ENTRIES)) >> RATIO_BITS;
            if (idx >= 64'(POW_ENTRIES)) begin
                idx = 64'(POW_ENTRIES - 1);
            end
            r.band = BAND_LT_050;
            pos = C_VIS_LOW * d0;
            neg = ((C_IR_LOW * d0) * 64'(pow_tab[idx])) >> 16;
        end else if (pct1 < 64'd61 * 64'(c0)) begin
            r.band = BAND_LT_061;
            pos = C_VIS_MID1 * d0;
            neg = C_IR_MID1 * d1;
        end else if (pct1 < 64'd80 * 64'(c0)) begin
            r.band = BAND_LT_080;
            pos = C_VIS_MID2 * d0;
            neg = C_IR_MID2 * d1;
        end else if (pct1 < 64'd130 * 64'(c0)) begin
            r.band = BAND_LT_130;
            pos = C_VIS_HIGH * d0;
            neg = C_IR_HIGH * d1;
        end else begin
            return r;
        end
        if (pos > neg) begin
            diff = (pos - neg) >> 20;
            r.lux = LUX_W'((diff > LUX_SAT) ? LUX_SAT : diff);
        end
        return r;
    endfunction

    function automatic t_counts make_counts(int c0, int c1);
        t_counts c;
        c.ch0 = CH_W'(c0);
        c.ch1 = CH_W'(c1);
        return c;
    endfunction

    function automatic t_counts random_counts();
        int sel;
        int c0;
        int c1;
        int lim;
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            c0 = $urandom_range(0, COUNT_FULL);
            c1 = $urandom_range(0, COUNT_FULL);
            if ($urandom_range(0, 1) == 0) begin
                c0 = COUNT_FULL;
            end else begin
                c1 = COUNT_FULL;
            end
        end else if (sel < 6) begin
            c0 = 0;
            c1 = $urandom_range(0, COUNT_FULL - 1);
        end else if (sel < 20) begin
            c0 = $urandom_range(0, COUNT_FULL);
            c1 = $urandom_range(0, COUNT_FULL);
        end else if (sel < 32) begin
            // Land exactly on or next to a band limit.
            case ($urandom_range(0, 3))
                0:       lim = 50;
                1:       lim = 61;
                2:       lim = 80;
                default: lim = 130;
            endcase
            c0 = 100 * $urandom_range(1, 655);
            c1 = (c0 / 100) * lim - 1 + $urandom_range(0, 2);
        end else begin
            case ($urandom_range(0, 3))
                0:       c0 = $urandom_range(1, 255);
                1:       c0 = $urandom_range(1, 4095);
                default: c0 = $urandom_range(1, COUNT_FULL - 1);
            endcase
            c1 = (c0 * $urandom_range(0, 150)) / 100 + $urandom_range(0, 2);
        end
        if (c1 > COUNT_FULL - 1 && sel >= 3) begin
            c1 = COUNT_FULL - 1;
        end
        return make_counts(c0, c1);
    endfunction

    task automatic wait_drained();
        while (counts_pending_q.size() != 0 || lux_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_scale(int value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= SCALE_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        scale_model = SCALE_W'(value);
        settings_used++;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            counts_pending_q.push_back(random_counts());
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        samp_bus.valid = 1'b0;
        samp_bus.ch0_count = '0;
        samp_bus.ch1_count = '0;
        lux_bus.ready = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results still expected.", lux_expected_q.size());
        $display("als_lux_from_channel_ratio_top_test NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            samp_bus.valid <= 1'b0;
            samp_bus.ch0_count <= '0;
            samp_bus.ch1_count <= '0;
            burst_left = $urandom_range(1, 40);
            gap_left = 0;
        end else begin
            offer_held = samp_bus.valid && !samp_bus.ready;
            if (samp_bus.valid && samp_bus.ready) begin
                lux_expected_q.push_back(predict_lux(samp_bus.ch0_count, samp_bus.ch1_count,
                                                     scale_model));
                counts_pending_q.delete(0);
                sent_count++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!offer_held) begin
                if (gap_left > 0) begin
                    gap_left--;
                    samp_bus.valid <= 1'b0;
                end else if (counts_pending_q.size() != 0) begin
                    samp_bus.valid <= 1'b1;
                    samp_bus.ch0_count <= counts_pending_q[0].ch0;
                    samp_bus.ch1_count <= counts_pending_q[0].ch1;
                end else begin
                    samp_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lux_bus.ready <= 1'b0;
            hold_left = 0;
            pat_pos = 0;
        end else begin
            if (lux_bus.valid && lux_bus.ready) begin
                checked_count++;
                if (lux_expected_q.size() == 0) begin
                    $display("%0t: unexpected transaction with lux %0d band %0d", $realtime,
                             lux_bus.lux_q8, lux_bus.ratio_band);
                    mismatches++;
                end else begin
                    lux_exp = lux_expected_q.pop_front();
                    band_hits[lux_exp.band]++;
                    if (lux_bus.lux_q8 !== lux_exp.lux || lux_bus.ratio_band !== lux_exp.band) begin
                        $display("%0t: mismatch, expected lux %0d band %0d, got lux %0d band %0d",
                                 $realtime, lux_exp.lux, lux_exp.band, lux_bus.lux_q8,
                                 lux_bus.ratio_band);
                        mismatches++;
                    end
                end
            end
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (pat_pos == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pat = '1;
                    1:       ready_pat = $urandom;
                    default: ready_pat = $urandom | $urandom;
                endcase
            end
            pat_pos = (pat_pos + 1) % 32;
            if (hold_left > 0) begin
                hold_left--;
                lux_bus.ready <= 1'b0;
            end else begin
                lux_bus.ready <= ready_pat[pat_pos];
            end
        end
    end

    initial begin
        mismatches = 0;
        sent_count = 0;
        checked_count = 0;
        settings_used = 1;
        hold_armed = 1'b0;
        hold_done = 1'b0;
        scale_model = SCALE_W'(SCALE_AT_RST);
        for (int b = 0; b < 6; b++) begin
            band_hits[b] = 0;
        end
        build_pow_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        counts_pending_q.push_back(make_counts(0, 0));
        counts_pending_q.push_back(make_counts(0, 5));
        counts_pending_q.push_back(make_counts(0, 65534));
        counts_pending_q.push_back(make_counts(65535, 0));
        counts_pending_q.push_back(make_counts(0, 65535));
        counts_pending_q.push_back(make_counts(65535, 65535));
        counts_pending_q.push_back(make_counts(65534, 0));
        counts_pending_q.push_back(make_counts(1, 0));
        counts_pending_q.push_back(make_counts(1, 1));
        counts_pending_q.push_back(make_counts(65534, 65534));
        counts_pending_q.push_back(make_counts(65534, 1));
        counts_pending_q.push_back(make_counts(3, 65534));
        counts_pending_q.push_back(make_counts(200, 99));
        counts_pending_q.push_back(make_counts(200, 100));
        counts_pending_q.push_back(make_counts(100, 60));
        counts_pending_q.push_back(make_counts(100, 61));
        counts_pending_q.push_back(make_counts(100, 79));
        counts_pending_q.push_back(make_counts(100, 80));
        counts_pending_q.push_back(make_counts(100, 129));
        counts_pending_q.push_back(make_counts(100, 130));
        counts_pending_q.push_back(make_counts(65534, 32766));
        counts_pending_q.push_back(make_counts(40000, 22000));
        counts_pending_q.push_back(make_counts(50000, 35000));
        counts_pending_q.push_back(make_counts(60000, 65000));

        write_scale(2047);
        queue_random(250);
        write_scale(0);
        queue_random(100);
        write_scale(1);
        queue_random(150);
        write_scale($urandom_range(2, 2046));
        hold_armed = 1'b1;
        queue_random(300);
        write_scale(SCALE_AT_RST);
        queue_random(200);
        wait_drained();
        queue_random(200);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d of %0d transactions over %0d integration scale settings.",
                 checked_count, sent_count, settings_used);
        $display("Results per band 0..5: %0d %0d %0d %0d %0d %0d.", band_hits[0], band_hits[1],
                 band_hits[2], band_hits[3], band_hits[4], band_hits[5]);
        if (mismatches == 0 && lux_expected_q.size() == 0) begin
            $display("als_lux_from_channel_ratio_top_test OK");
        end else begin
            $display("als_lux_from_channel_ratio_top_test NOT OK");
        end
        $finish;
    end

endmodule
